### rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Shared widths, command codes and item types of the Bresenham line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int COORD_WIDTH = 11;
    localparam int ERR_WIDTH   = COORD_WIDTH + 2;

    typedef logic [COORD_WIDTH-1:0]      coord_t;
    typedef logic signed [ERR_WIDTH-1:0] err_t;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef struct packed {
        logic   command;
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
    } cmd_item_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last;
    } pixel_item_t;

    // Line state loaded by a start command
    typedef struct packed {
        coord_t cur_x;
        coord_t cur_y;
        coord_t major_end;
        err_t   error_term;
        err_t   straight_add;
        err_t   diagonal_add;
        logic   x_is_major;
        logic   minor_down;
        logic   single_point;
    } line_setup_t;

endpackage

### rtl/bls_setup.sv
// ----------------------------------------------------------------------------
// bls_setup
// Endpoint ordering and Bresenham term setup for a start command.
// ----------------------------------------------------------------------------
module bls_setup
    import bls_pkg::*;
(
    input  cmd_item_t   cmd,
    output line_setup_t setup
);

    coord_t dx;
    coord_t dy;
    coord_t dmaj;
    coord_t dmin;
    coord_t s_maj;
    coord_t s_min;
    coord_t e_maj;
    coord_t e_min;
    logic   x_major;
    logic   a_first;
    err_t   dmaj_e;
    err_t   dmin_e;

    always_comb
    begin
        dx = (cmd.x_start > cmd.x_end) ? cmd.x_start - cmd.x_end : cmd.x_end - cmd.x_start;
        dy = (cmd.y_start > cmd.y_end) ? cmd.y_start - cmd.y_end : cmd.y_end - cmd.y_start;
        x_major = (dx >= dy);

        // order so the major coordinate rises; on a tie the second endpoint leads
        if (x_major)
        begin
            dmaj    = dx;
            dmin    = dy;
            a_first = (cmd.x_start < cmd.x_end);
        end
        else
        begin
            dmaj    = dy;
            dmin    = dx;
            a_first = (cmd.y_start < cmd.y_end);
        end

        if (x_major)
        begin
            s_maj = a_first ? cmd.x_start : cmd.x_end;
            s_min = a_first ? cmd.y_start : cmd.y_end;
            e_maj = a_first ? cmd.x_end   : cmd.x_start;
            e_min = a_first ? cmd.y_end   : cmd.y_start;
        end
        else
        begin
            s_maj = a_first ? cmd.y_start : cmd.y_end;
            s_min = a_first ? cmd.x_start : cmd.x_end;
            e_maj = a_first ? cmd.y_end   : cmd.y_start;
            e_min = a_first ? cmd.x_end   : cmd.x_start;
        end

        dmaj_e = err_t'({2'b00, dmaj});
        dmin_e = err_t'({2'b00, dmin});

        setup.cur_x        = x_major ? s_maj : s_min;
        setup.cur_y        = x_major ? s_min : s_maj;
        setup.major_end    = e_maj;
        setup.error_term   = (dmin_e <<< 1) - dmaj_e;
        setup.straight_add = dmin_e <<< 1;
        setup.diagonal_add = (dmin_e - dmaj_e) <<< 1;
        setup.x_is_major   = x_major;
        setup.minor_down   = (e_min < s_min);
        setup.single_point = (dmaj == '0);
    end

endmodule

### rtl/bresenham_line_stepper_unit.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper_unit
// Integer Bresenham line rasterizer for all octants, at most one pixel per command.
// ----------------------------------------------------------------------------
// A start command loads two endpoints and returns the first pixel; each step
// command returns the next pixel, with last set on the far endpoint. A step
// while no line is running returns nothing. The line state updates in the accepting
// cycle (one error add and one endpoint compare) and the pixel lands in an output
// register, so a new command is taken every cycle as long as the output register
// is empty or being drained. The pixel is valid in the cycle after acceptance.
module bresenham_line_stepper_unit
    import bls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_item_t   cmd,
    output logic        pixel_valid,
    input  logic        pixel_ready,
    output pixel_item_t pixel
);

    coord_t      cur_x_reg, cur_x_next;
    coord_t      cur_y_reg, cur_y_next;
    coord_t      major_end_reg, major_end_next;
    err_t        error_term_reg, error_term_next;
    err_t        straight_add_reg, straight_add_next;
    err_t        diagonal_add_reg, diagonal_add_next;
    logic        x_is_major_reg, x_is_major_next;
    logic        minor_down_reg, minor_down_next;
    logic        active_reg, active_next;
    logic        out_valid_reg, out_valid_next;
    pixel_item_t pixel_reg, pixel_next;

    line_setup_t setup;
    logic        accept;
    coord_t      maj;
    coord_t      mnr;
    coord_t      maj_step;
    coord_t      mnr_step;
    err_t        err_step;
    logic        fin;

    bls_setup u_setup (
        .cmd   (cmd),
        .setup (setup)
    );

    assign cmd_ready   = !out_valid_reg || pixel_ready;
    assign accept      = cmd_valid && cmd_ready;
    assign pixel_valid = out_valid_reg;
    assign pixel       = pixel_reg;

    // One Bresenham step from the held line state
    always_comb
    begin
        maj = x_is_major_reg ? cur_x_reg : cur_y_reg;
        mnr = x_is_major_reg ? cur_y_reg : cur_x_reg;
        maj_step = maj + coord_t'(1);
        if (error_term_reg[ERR_WIDTH-1])
        begin
            mnr_step = mnr;
            err_step = error_term_reg + straight_add_reg;
        end
        else
        begin
            mnr_step = minor_down_reg ? mnr - coord_t'(1) : mnr + coord_t'(1);
            err_step = error_term_reg + diagonal_add_reg;
        end
        fin = (maj_step == major_end_reg);
    end

    always_comb
    begin
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        major_end_next    = major_end_reg;
        error_term_next   = error_term_reg;
        straight_add_next = straight_add_reg;
        diagonal_add_next = diagonal_add_reg;
        x_is_major_next   = x_is_major_reg;
        minor_down_next   = minor_down_reg;
        active_next       = active_reg;
        pixel_next        = pixel_reg;
        out_valid_next    = out_valid_reg && !pixel_ready;

        if (accept)
        begin
            case (cmd.command)
                CMD_START:
                begin
                    cur_x_next        = setup.cur_x;
                    cur_y_next        = setup.cur_y;
                    major_end_next    = setup.major_end;
                    error_term_next   = setup.error_term;
                    straight_add_next = setup.straight_add;
                    diagonal_add_next = setup.diagonal_add;
                    x_is_major_next   = setup.x_is_major;
                    minor_down_next   = setup.minor_down;
                    active_next       = !setup.single_point;
                    pixel_next.pixel_x = setup.cur_x;
                    pixel_next.pixel_y = setup.cur_y;
                    pixel_next.last    = setup.single_point;
                    out_valid_next     = 1'b1;
                end
                CMD_STEP:
                begin
                    // drop a step while idle
                    if (active_reg)
                    begin
                        cur_x_next      = x_is_major_reg ? maj_step : mnr_step;
                        cur_y_next      = x_is_major_reg ? mnr_step : maj_step;
                        error_term_next = err_step;
                        active_next     = !fin;
                        pixel_next.pixel_x = x_is_major_reg ? maj_step : mnr_step;
                        pixel_next.pixel_y = x_is_major_reg ? mnr_step : maj_step;
                        pixel_next.last    = fin;
                        out_valid_next     = 1'b1;
                    end
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !pixel_ready;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            major_end_reg    <= '0;
            error_term_reg   <= '0;
            straight_add_reg <= '0;
            diagonal_add_reg <= '0;
            x_is_major_reg   <= 1'b1;
            minor_down_reg   <= 1'b0;
            active_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            major_end_reg    <= major_end_next;
            error_term_reg   <= error_term_next;
            straight_add_reg <= straight_add_next;
            diagonal_add_reg <= diagonal_add_next;
            x_is_major_reg   <= x_is_major_next;
            minor_down_reg   <= minor_down_next;
            active_reg       <= active_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

endmodule
